@@ hdl/gbk_pkg.sv @@
// ----------------------------------------------------------------------------
// gbk_pkg: shared types and constants of the Gaussian blur block
// Geometry limits, register indexes, kernel weights and the reciprocal used
// for the division by 179.
// ----------------------------------------------------------------------------
package gbk_pkg;

  // Longest line that the line stores hold.
  localparam int LINE_MAX = 4096;
  localparam int COL_W    = $clog2(LINE_MAX);
  localparam int EW_W     = $clog2(LINE_MAX + 1);
  localparam int SEEN_CAP = 2 * LINE_MAX + 2;
  localparam int SEEN_W   = $clog2(SEEN_CAP + 1);

  // Fixed widths of the registers and position counters.
  // The row counter spans every height that the register can hold.
  localparam int LW_W  = 13;
  localparam int FH_W  = 14;
  localparam int ROW_W = 14;
  localparam int CFG_W = 14;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Reset values of the registers.
  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 14'd480;

  // Window geometry: five columns of five rows.
  localparam int KSPAN = 5;
  localparam int PIX_W = 8;

  // Sum widths and the reciprocal of 179 scaled by 2**24.
  localparam int SUM_W   = 16;
  localparam int RECIP_W = 17;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_179 = 17'd93728;
  localparam int Q_W = 12;

  typedef logic [KSPAN-1:0][PIX_W-1:0] col_t;
  typedef col_t [KSPAN-1:0] win_t;

  // Control that travels along the arithmetic stages.
  typedef struct packed {
    logic             valid;
    logic             inner;
    logic             mode;
    logic [PIX_W-1:0] center;
  } ctl_t;

  typedef logic [5:0] wt_t;
  typedef wt_t [KSPAN-1:0][KSPAN-1:0] wt_tab_t;

  // Weights indexed [column age][rows back]; the small kernel uses indexes 0 to 2 of both.
  localparam wt_tab_t WT3 = '{
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd0, 6'd0, 6'd1, 6'd2, 6'd1},
    '{6'd0, 6'd0, 6'd2, 6'd4, 6'd2},
    '{6'd0, 6'd0, 6'd1, 6'd2, 6'd1}
  };
  localparam wt_tab_t WT5 = '{
    '{6'd0, 6'd0, 6'd1,  6'd0, 6'd0},
    '{6'd0, 6'd8, 6'd21, 6'd8, 6'd0},
    '{6'd1, 6'd21, 6'd59, 6'd21, 6'd1},
    '{6'd0, 6'd8, 6'd21, 6'd8, 6'd0},
    '{6'd0, 6'd0, 6'd1,  6'd0, 6'd0}
  };

  // Weight of one window tap for the selected kernel.
  function automatic wt_t weight(input logic mode, input logic [2:0] k,
                                 input logic [2:0] r);
    return mode ? WT5[k][r] : WT3[k][r];
  endfunction

endpackage

@@ hdl/gbk_linebuf.sv @@
// ----------------------------------------------------------------------------
// gbk_linebuf: four line stores in one memory
// Each word holds the pixel of one column for all four stored lines; a
// request reads the whole word and writes its own byte into the current slot.
// ----------------------------------------------------------------------------
module gbk_linebuf (
  input  logic                     clk,
  input  logic                     en,
  input  logic [gbk_pkg::COL_W-1:0] addr,
  input  logic [1:0]               slot,
  input  logic [gbk_pkg::PIX_W-1:0] wdata,
  output logic [3:0][gbk_pkg::PIX_W-1:0] rdata
);

  logic [3:0][gbk_pkg::PIX_W-1:0] mem [gbk_pkg::LINE_MAX];

  // Read the old word and write the new byte at the same column.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata           <= mem[addr];
      mem[addr][slot] <= wdata;
    end
  end

endmodule

@@ hdl/gbk_cell.sv @@
// ----------------------------------------------------------------------------
// gbk_cell: one column of the window
// Holds five pixels of one column and takes its neighbor's column on a shift.
// ----------------------------------------------------------------------------
module gbk_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  gbk_pkg::col_t col_in,
  output gbk_pkg::col_t col_out
);

  // The window starts out all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

@@ hdl/gbk_conv.sv @@
// ----------------------------------------------------------------------------
// gbk_conv: weighted sum of the window
// Column sums, the total and the product with the reciprocal of 179, each
// stage registered.
// ----------------------------------------------------------------------------
module gbk_conv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  gbk_pkg::ctl_t               ctl_in,
  input  gbk_pkg::win_t               win,
  output gbk_pkg::ctl_t               ctl_out,
  output logic [gbk_pkg::SUM_W-1:0]   total_out,
  output logic [gbk_pkg::PROD_W-1:0]  prod_out
);

  logic [gbk_pkg::SUM_W-1:0] csum_next [gbk_pkg::KSPAN];
  logic [gbk_pkg::SUM_W-1:0] csum [gbk_pkg::KSPAN];
  logic [gbk_pkg::SUM_W-1:0] total_next;
  logic [gbk_pkg::SUM_W-1:0] total;
  gbk_pkg::ctl_t c_ctl;
  gbk_pkg::ctl_t d_ctl;

  // Weighted sum of each column with constant weights.
  // Taps with zero weight are left out, so taps outside the kernel never
  // reach the sum.
  always_comb begin
    for (int k = 0; k < gbk_pkg::KSPAN; k++) begin
      csum_next[k] = '0;
      for (int r = 0; r < gbk_pkg::KSPAN; r++) begin
        if (gbk_pkg::weight(ctl_in.mode, 3'(k), 3'(r)) != '0) begin
          csum_next[k] = csum_next[k]
            + gbk_pkg::SUM_W'(gbk_pkg::weight(ctl_in.mode, 3'(k), 3'(r)))
            * gbk_pkg::SUM_W'(win[k][r]);
        end
      end
    end
  end

  // Sum of the five column sums.
  always_comb begin
    total_next = '0;
    for (int k = 0; k < gbk_pkg::KSPAN; k++) begin
      total_next = total_next + csum[k];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl.valid   <= 1'b0;
      d_ctl.valid   <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      c_ctl.valid   <= ctl_in.valid;
      d_ctl.valid   <= c_ctl.valid;
      ctl_out.valid <= d_ctl.valid;
    end
  end

  // Stage payload: column sums, total, product.
  always_ff @(posedge clk) begin
    if (adv) begin
      csum          <= csum_next;
      c_ctl.inner   <= ctl_in.inner;
      c_ctl.mode    <= ctl_in.mode;
      c_ctl.center  <= ctl_in.mode ? win[2][2] : win[1][1];
      total         <= total_next;
      d_ctl.inner   <= c_ctl.inner;
      d_ctl.mode    <= c_ctl.mode;
      d_ctl.center  <= c_ctl.center;
      total_out     <= total;
      prod_out      <= gbk_pkg::PROD_W'(total) * gbk_pkg::PROD_W'(gbk_pkg::RECIP_179);
      ctl_out.inner <= d_ctl.inner;
      ctl_out.mode  <= d_ctl.mode;
      ctl_out.center <= d_ctl.center;
    end
  end

endmodule

@@ hdl/gaussian_blur_3x3_5x5.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_5x5: streaming 3x3 / 5x5 Gaussian blur of grey frames
// Line stores feed a row of five column cells; a pipelined adder tree and a
// reciprocal multiply (5x5) or a shift by four (3x3) give the blurred centre pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (s_tvalid/s_tready) carry one pixel each in raster order;
//   s_tuser set marks a padding request that advances the position with
//   value 0, used to flush the end of a frame. Output requests
//   (m_tvalid/m_tready) carry the filtered or copied centre pixel, with
//   m_tuser set when it was convolved.
//   One pixel is taken every cycle unless the output stalls. Once primed,
//   each input request yields one result, for the pixel half a kernel
//   of rows and columns back; it is offered on the output after the line
//   store read at the accepting edge, then window shift, column sums,
//   total, multiply and output register.
//   A stall on the output holds the whole pipeline and drops s_tready in
//   the same cycle; nothing is lost.
//   Reset clears the position, the window and the priming, and loads the register
//   defaults. Registers are written through cfg_we/cfg_index/cfg_data by the user
//   only while the block is idle, which the block itself does not enforce; a geometry write restarts the raster.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_5x5 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        s_tuser,   // [0] padding
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_pixel
  output logic        m_tuser,   // [0] filtered
  input  logic        cfg_we,
  input  logic [gbk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbk_pkg::CFG_W-1:0]     cfg_data
);

  logic                          kernel_mode;
  logic [gbk_pkg::LW_W-1:0]      line_width;
  logic [gbk_pkg::FH_W-1:0]      frame_height;
  logic [gbk_pkg::EW_W-1:0]      w;
  logic [gbk_pkg::FH_W-1:0]      h;
  logic [1:0]                    half;
  logic [2:0]                    span;
  logic [gbk_pkg::SEEN_W-1:0]    lag;
  logic [gbk_pkg::COL_W-1:0]     col;
  logic [gbk_pkg::ROW_W-1:0]     row;
  logic [1:0]                    slot;
  logic [gbk_pkg::SEEN_W-1:0]    seen;
  logic                          primed;
  logic                          primed_next;
  logic                          accept;
  logic                          adv;
  logic                          geom_wr;
  logic [gbk_pkg::EW_W-1:0]      col_inc;
  logic [gbk_pkg::FH_W-1:0]      row_inc;
  logic [gbk_pkg::EW_W-1:0]      cx;
  logic [gbk_pkg::FH_W-1:0]      cy;
  logic [gbk_pkg::FH_W-1:0]      rsub;
  logic                          cx_ok;
  logic                          inner_next;
  logic [gbk_pkg::PIX_W-1:0]     cur;

  logic                          a_valid;
  logic                          a_emit;
  logic                          a_inner;
  logic                          a_mode;
  logic [1:0]                    a_slot;
  logic [gbk_pkg::PIX_W-1:0]     a_cur;
  logic [3:0][gbk_pkg::PIX_W-1:0] rdata;
  gbk_pkg::col_t                 col_in;
  gbk_pkg::win_t                 win;
  gbk_pkg::ctl_t                 b_ctl;
  gbk_pkg::ctl_t                 e_ctl;
  logic [gbk_pkg::SUM_W-1:0]     e_total;
  logic [gbk_pkg::PROD_W-1:0]    e_prod;
  logic [gbk_pkg::Q_W-1:0]       quot;

  // The pipeline moves whenever the output register is free or drained.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign cur      = s_tuser ? '0 : s_tdata;
  assign geom_wr  = cfg_we && (cfg_index == gbk_pkg::CFG_LINE_WIDTH ||
                               cfg_index == gbk_pkg::CFG_FRAME_HEIGHT);

  // Effective geometry and kernel size.
  always_comb begin
    if (line_width == '0) begin
      w = gbk_pkg::EW_W'(1);
    end else if (32'(line_width) > gbk_pkg::LINE_MAX) begin
      w = gbk_pkg::EW_W'(gbk_pkg::LINE_MAX);
    end else begin
      w = gbk_pkg::EW_W'(line_width);
    end
    h    = (frame_height == '0) ? gbk_pkg::FH_W'(1) : frame_height;
    half = kernel_mode ? 2'd2 : 2'd1;
    span = kernel_mode ? 3'd5 : 3'd3;
    lag  = kernel_mode ? gbk_pkg::SEEN_W'({w, 1'b0}) + gbk_pkg::SEEN_W'(2)
                       : gbk_pkg::SEEN_W'(w) + gbk_pkg::SEEN_W'(1);
    primed_next = primed || (seen >= lag);
    col_inc = gbk_pkg::EW_W'(col) + gbk_pkg::EW_W'(1);
    row_inc = gbk_pkg::FH_W'(row) + gbk_pkg::FH_W'(1);
  end

  // Position of the centre pixel and whether it lies inside the border.
  // The bottom edge test is one bit wider so the tallest heights cannot wrap.
  always_comb begin
    cx_ok = gbk_pkg::EW_W'(col) >= gbk_pkg::EW_W'(half);
    cx    = cx_ok ? gbk_pkg::EW_W'(col) - gbk_pkg::EW_W'(half)
                  : gbk_pkg::EW_W'(col) + w - gbk_pkg::EW_W'(half);
    rsub  = gbk_pkg::FH_W'(half) + gbk_pkg::FH_W'(!cx_ok);
    cy    = (gbk_pkg::FH_W'(row) >= rsub) ? gbk_pkg::FH_W'(row) - rsub
                                          : gbk_pkg::FH_W'(row) + h - rsub;
    inner_next = (w >= gbk_pkg::EW_W'(span)) && (h >= gbk_pkg::FH_W'(span)) &&
                 (cx >= gbk_pkg::EW_W'(half)) &&
                 ((cx + gbk_pkg::EW_W'(half)) < w) &&
                 (cy >= gbk_pkg::FH_W'(half)) &&
                 (((gbk_pkg::FH_W+1)'(cy) + (gbk_pkg::FH_W+1)'(half)) <
                  (gbk_pkg::FH_W+1)'(h));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode  <= 1'b0;
      line_width   <= gbk_pkg::LINE_WIDTH_RST;
      frame_height <= gbk_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbk_pkg::CFG_KERNEL_MODE:  kernel_mode  <= cfg_data[0];
        gbk_pkg::CFG_LINE_WIDTH:   line_width   <= cfg_data[gbk_pkg::LW_W-1:0];
        gbk_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[gbk_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position, line slot and priming.
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      slot   <= '0;
      seen   <= '0;
      primed <= 1'b0;
    end else begin
      if (geom_wr) begin
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col_inc >= w) begin
          col <= '0;
          row <= (row_inc >= h) ? '0 : row_inc[gbk_pkg::ROW_W-1:0];
        end else begin
          col <= col_inc[gbk_pkg::COL_W-1:0];
        end
      end
      if (accept) begin
        if (col_inc >= w) begin
          slot <= slot + 2'd1;
        end
        if (32'(seen) < gbk_pkg::SEEN_CAP) begin
          seen <= seen + gbk_pkg::SEEN_W'(1);
        end
        primed <= primed_next;
      end
    end
  end

  // Line stores.
  gbk_linebuf u_linebuf (
    .clk   (clk),
    .en    (accept),
    .addr  (col),
    .slot  (slot),
    .wdata (cur),
    .rdata (rdata)
  );

  // Stage A: request registered alongside the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cur   <= cur;
      a_slot  <= slot;
      a_emit  <= primed_next;
      a_inner <= inner_next;
      a_mode  <= kernel_mode;
    end
  end

  // New column: current pixel over the four stored lines, newest first.
  always_comb begin
    col_in[0] = a_cur;
    for (int r = 1; r < gbk_pkg::KSPAN; r++) begin
      col_in[r] = rdata[a_slot - 2'(r)];
    end
  end

  // Stage B: the window, a row of column cells shifting one step per request.
  for (genvar k = 0; k < gbk_pkg::KSPAN; k++) begin : g_cell
    gbk_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (adv && a_valid),
      .col_in  ((k == 0) ? col_in : win[(k == 0) ? 0 : k-1]),
      .col_out (win[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl.valid <= 1'b0;
    end else if (adv) begin
      b_ctl.valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl.inner  <= a_inner;
      b_ctl.mode   <= a_mode;
      b_ctl.center <= '0;
    end
  end

  // Stages C to E: weighted sum and reciprocal multiply.
  gbk_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (b_ctl),
    .win       (win),
    .ctl_out   (e_ctl),
    .total_out (e_total),
    .prod_out  (e_prod)
  );

  // Quotient by 16 or by 179.
  assign quot = e_ctl.mode ? gbk_pkg::Q_W'(e_prod >> gbk_pkg::RECIP_SHIFT)
                           : gbk_pkg::Q_W'(e_total >> 4);

  // Output register: clamp and choose between blurred and copied pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= e_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= e_ctl.inner;
      if (!e_ctl.inner) begin
        m_tdata <= e_ctl.center;
      end else if (quot > gbk_pkg::Q_W'(255)) begin
        m_tdata <= 8'hFF;
      end else begin
        m_tdata <= quot[7:0];
      end
    end
  end

`ifndef SYNTHESIS
  // No result leaves right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A geometry write restarts the raster position.
  a_geom_restart: assert property (@(posedge clk) disable iff (rst)
    geom_wr |=> (col == '0 && row == '0))
    else $error("raster position not restarted by geometry write");

  // A request that yields a result has primed the block.
  a_emit_primed: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_emit) |-> primed)
    else $error("result requested before priming");

  // The request count saturates.
  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    32'(seen) <= gbk_pkg::SEEN_CAP)
    else $error("request count past its cap");
`endif

endmodule
